@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset has been released.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset or not.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/sldm_pkg.sv @@
package sldm_pkg;

    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 5;
    localparam int CAP_W   = 6;
    localparam int STAT_W  = 2;

    typedef logic [CMD_W-1:0]          cmd_t;
    typedef logic [STAT_W-1:0]         status_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [INDEX_W-1:0]        index_t;
    typedef logic [CAP_W-1:0]          cap_t;

    localparam cmd_t CMD_APPEND  = 2'd0;
    localparam cmd_t CMD_DELMIN  = 2'd1;
    localparam cmd_t CMD_REVERSE = 2'd2;
    localparam cmd_t CMD_READ    = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

    localparam cap_t CAP_RESET = 6'd32;

endpackage

@@ rtl/core/sldm_if.sv @@
interface sldm_in_if;
    logic                valid;
    logic                ready;
    sldm_pkg::cmd_t      command;
    sldm_pkg::value_t    value;
    sldm_pkg::index_t    index;

    modport source (output valid, output command, output value, output index, input ready);
    modport sink   (input valid, input command, input value, input index, output ready);
endinterface

interface sldm_out_if #(parameter int CNT_W = 6);
    logic                valid;
    logic                ready;
    sldm_pkg::value_t    result_value;
    sldm_pkg::status_t   status;
    logic [CNT_W-1:0]    count;

    modport source (output valid, output result_value, output status, output count,
                    input ready);
    modport sink   (input valid, input result_value, input status, input count,
                    output ready);
endinterface

@@ rtl/core/sldm_store.sv @@
module sldm_store #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  sldm_pkg::value_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output sldm_pkg::value_t rd_data
);

    sldm_pkg::value_t mem [DEPTH];
    sldm_pkg::value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/sldm_ctrl.sv @@
`include "assert_macros.svh"

module sldm_ctrl #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int WW = (CW > sldm_pkg::CAP_W) ? CW : sldm_pkg::CAP_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CW-1:0]    limit,
    sldm_in_if.sink          request,
    sldm_out_if.source       response,
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output sldm_pkg::value_t wr_data,
    output logic             rd_en,
    output logic [AW-1:0]    rd_addr,
    input  sldm_pkg::value_t rd_data
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN      = 4'd1;
    localparam logic [3:0] S_SCAN_WAIT = 4'd2;
    localparam logic [3:0] S_SHIFT     = 4'd3;
    localparam logic [3:0] S_RV_LO     = 4'd4;
    localparam logic [3:0] S_RV_HI     = 4'd5;
    localparam logic [3:0] S_RV_WLO    = 4'd6;
    localparam logic [3:0] S_RV_WHI    = 4'd7;
    localparam logic [3:0] S_RD_WAIT   = 4'd8;
    localparam logic [3:0] S_FIN       = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic                rv_scan_reg, rv_scan_next;
    logic                rv_shift_reg, rv_shift_next;

    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       ridx_reg, ridx_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       lo_reg, lo_next;
    logic [AW-1:0]       hi_reg, hi_next;
    sldm_pkg::value_t    best_reg, best_next;
    sldm_pkg::value_t    tmp_reg, tmp_next;
    sldm_pkg::value_t    res_reg, res_next;
    sldm_pkg::status_t   st_reg, st_next;
    sldm_pkg::value_t    out_value_reg, out_value_next;
    sldm_pkg::status_t   out_status_reg, out_status_next;
    logic [CW-1:0]       out_count_reg, out_count_next;

    logic [CW-1:0]       cm1;
    logic                better;

    assign cm1    = count_reg - 1'b1;
    assign better = (ridx_reg == '0) || (rd_data < best_reg);

    assign request.ready         = (state_reg == S_IDLE);
    assign response.valid        = out_valid_reg;
    assign response.result_value = out_value_reg;
    assign response.status       = out_status_reg;
    assign response.count        = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        rv_scan_next    = 1'b0;
        rv_shift_next   = 1'b0;
        ptr_next        = ptr_reg;
        ridx_next       = ridx_reg;
        pos_next        = pos_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        best_next       = best_reg;
        tmp_next        = tmp_reg;
        res_next        = res_reg;
        st_next         = st_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = '0;

        if (out_valid_reg && response.ready)
        begin
            out_valid_next = 1'b0;
        end

        // scan compare and shift write-back act in the cycle after the read
        if (rv_scan_reg && better)
        begin
            best_next = rd_data;
            pos_next  = ridx_reg;
        end
        if (rv_shift_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = ridx_reg - 1'b1;
            wr_data = rd_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    res_next   = '0;
                    st_next    = sldm_pkg::ST_OK;
                    state_next = S_FIN;
                    case (request.command)
                        sldm_pkg::CMD_APPEND:
                        begin
                            if (count_reg >= limit)
                            begin
                                st_next = sldm_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = request.value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        sldm_pkg::CMD_DELMIN:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = sldm_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        sldm_pkg::CMD_REVERSE:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                lo_next    = '0;
                                hi_next    = cm1[AW-1:0];
                                state_next = S_RV_LO;
                            end
                        end
                        sldm_pkg::CMD_READ:
                        begin
                            if (WW'(request.index) >= WW'(count_reg))
                            begin
                                st_next = sldm_pkg::ST_RANGE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(request.index);
                                state_next = S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                rd_en        = 1'b1;
                rd_addr      = ptr_reg[AW-1:0];
                rv_scan_next = 1'b1;
                ridx_next    = ptr_reg[AW-1:0];
                ptr_next     = ptr_reg + 1'b1;
                if (ptr_reg == cm1)
                begin
                    state_next = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT:
            begin
                res_next   = best_next;
                ptr_next   = CW'(pos_next) + 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (ptr_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = ptr_reg[AW-1:0];
                    rv_shift_next = 1'b1;
                    ridx_next     = ptr_reg[AW-1:0];
                    ptr_next      = ptr_reg + 1'b1;
                end
                else
                begin
                    count_next = cm1;
                    state_next = S_FIN;
                end
            end
            S_RV_LO:
            begin
                rd_en      = 1'b1;
                rd_addr    = lo_reg;
                state_next = S_RV_HI;
            end
            S_RV_HI:
            begin
                tmp_next   = rd_data;
                rd_en      = 1'b1;
                rd_addr    = hi_reg;
                state_next = S_RV_WLO;
            end
            S_RV_WLO:
            begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg;
                wr_data    = rd_data;
                state_next = S_RV_WHI;
            end
            S_RV_WHI:
            begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = tmp_reg;
                lo_next = lo_reg + 1'b1;
                hi_next = hi_reg - 1'b1;
                if ((lo_reg + 1'b1) < (hi_reg - 1'b1))
                begin
                    state_next = S_RV_LO;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_RD_WAIT:
            begin
                res_next   = rd_data;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_reg;
                    out_status_next = st_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rv_scan_reg   <= 1'b0;
            rv_shift_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rv_scan_reg   <= rv_scan_next;
            rv_shift_reg  <= rv_shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        ridx_reg       <= ridx_next;
        pos_reg        <= pos_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        best_reg       <= best_next;
        tmp_reg        <= tmp_next;
        res_reg        <= res_next;
        st_reg         <= st_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    `ASSERT_RST(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "entry count beyond depth")
    `ASSERT_RST(a_wr_in_list, clk, rst_n, wr_en |-> (CW'(wr_addr) <= count_reg), "write past list end")
    `ASSERT_RST(a_no_rw_clash, clk, rst_n, (wr_en && rd_en) |-> (wr_addr != rd_addr), "read and write hit one entry")

endmodule

@@ rtl/core/sequential_list_delete_min.sv @@
// Packed list of signed 32-bit values held in a single on-chip RAM with one
// write and one registered read port. Commands: append, delete-minimum,
// reverse, read-at-index; each returns exactly one response transaction with
// the value, a status and the entry count after the command. One command is
// worked on at a time; a new request is taken as soon as the sequencer is idle,
// even while the previous response still waits. Delete-minimum makes one RAM
// read per entry for the scan, then one read and write per later entry for
// the shift; reverse makes two reads and two writes per swapped pair through
// the single write port.
// The capacity register may only be written while no command is in flight.
module sequential_list_delete_min #(
    parameter int DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  sldm_pkg::cap_t       cfg_wr_data,
    sldm_in_if.sink              request,
    sldm_out_if.source           response
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > sldm_pkg::CAP_W) ? CW : sldm_pkg::CAP_W;

    sldm_pkg::cap_t   capacity_reg;
    logic [WW-1:0]    cap_ext;
    logic [WW-1:0]    limit_wide;
    logic [CW-1:0]    limit;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    sldm_pkg::value_t wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    sldm_pkg::value_t rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= sldm_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    assign cap_ext    = WW'(capacity_reg);
    assign limit_wide = (cap_ext < WW'(DEPTH)) ? cap_ext : WW'(DEPTH);
    assign limit      = limit_wide[CW-1:0];

    sldm_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sldm_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .limit    (limit),
        .request  (request),
        .response (response),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

endmodule
